@@ hw/rtl/vfh_pkg.sv @@
// Package: shared constants, codes, types and control structs for the flow histogram.
`timescale 1ns / 1ps
`default_nettype none
package vfh_pkg;

  localparam int MAX_EDGE   = 64;
  localparam int EDGE_W     = $clog2(MAX_EDGE);
  localparam int ADDR_W     = 2 * EDGE_W;
  localparam int CNT_W      = 32;
  localparam int FLOW_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = FLOW_W + CFG_W + 1;
  localparam int RMAG_W     = PROD_W - FRAC_BITS;
  localparam int BINV_W     = RMAG_W + 2;

  localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [CFG_W-1:0] BPU_RESET   = CFG_W'(8);
  localparam logic [CFG_W-1:0] EDGE_RESET  = CFG_W'(24);
  localparam logic [CFG_W-1:0] EDGE_LIMIT  = CFG_W'(MAX_EDGE);

  typedef enum logic {
    FUNC_ACCUM = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BINS_PER_UNIT = 2'd0,
    REG_EDGE_BINS     = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RND,
    S_BIN,
    S_RD,
    S_UPD
  } ctrl_state_t;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic mul;
    logic rnd;
    logic bin;
    logic rd;
    logic upd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/vfh_in_if.sv @@
// Interface: input item channel.
`timescale 1ns / 1ps
`default_nettype none
interface vfh_in_if;
  import vfh_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [FLOW_W-1:0] flow_x;
  logic signed [FLOW_W-1:0] flow_y;
  logic                     counted;
  logic [EDGE_W-1:0]        read_col;
  logic [EDGE_W-1:0]        read_row;

  modport source (output valid, func, flow_x, flow_y, counted, read_col, read_row,
                  input ready);
  modport sink (input valid, func, flow_x, flow_y, counted, read_col, read_row,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vfh_out_if.sv @@
// Interface: result item channel.
`timescale 1ns / 1ps
`default_nettype none
interface vfh_out_if;
  import vfh_pkg::*;

  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] bin_col;
  logic [EDGE_W-1:0] bin_row;
  logic [CNT_W-1:0]  count;

  modport source (output valid, bin_col, bin_row, count, input ready);
  modport sink (input valid, bin_col, bin_row, count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vfh_cfg_if.sv @@
// Interface: configuration register write channel.
`timescale 1ns / 1ps
`default_nettype none
interface vfh_cfg_if;
  import vfh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink (input valid, wr_index, wr_data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vector_field_histogram_2d.sv @@
// Top level: 2-D histogram of flow vectors with controller and datapath.
//
//   channel   dir  handshake       payload
//   in_ch     in   valid / ready   func, flow_x, flow_y, counted, read_col, read_row
//   out_ch    out  valid / ready   bin_col, bin_row, count
//   cfg_ch    in   valid / ready   wr_index, wr_data (bins_per_unit = 0, edge_bins = 1)
//
// An accumulate transaction steps through multiply, round, clamp, memory read and update
// before the next accept; a read transaction steps through memory read and update only.
// Counted accumulate items read-modify-write the 4096 x 32 count memory.
// After reset a clearing sweep writes zero to all 4096 entries;
// in_ch.ready stays low meanwhile, cfg_ch is always ready.
// A result waiting on out_ch holds the next update in its last cycle until taken.
`timescale 1ns / 1ps
`default_nettype none
module vector_field_histogram_2d (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vfh_in_if.sink     in_ch,
  vfh_out_if.source  out_ch,
  vfh_cfg_if.sink    cfg_ch
);
  import vfh_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_rdy;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  vfh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  vfh_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.wr_index),
    .cfg_data    (cfg_ch.wr_data),
    .in_func     (in_ch.func),
    .in_flow_x   (in_ch.flow_x),
    .in_flow_y   (in_ch.flow_y),
    .in_counted  (in_ch.counted),
    .in_read_col (in_ch.read_col),
    .in_read_row (in_ch.read_row),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_bin_col (out_ch.bin_col),
    .out_bin_row (out_ch.bin_row),
    .out_count   (out_ch.count)
  );

endmodule
`default_nettype wire

@@ hw/rtl/vfh_ctrl.sv @@
// Controller: sequences clearing, binning, memory read and count update.
`timescale 1ns / 1ps
`default_nettype none
module vfh_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_func,
  output logic                in_ready,
  input  wire vfh_pkg::ctrl_sts_t sts,
  output vfh_pkg::ctrl_cmd_t  cmd
);
  import vfh_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (func_t'(in_func) == FUNC_READ) ? S_RD : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_BIN;
      end
      S_BIN: begin
        cmd.bin   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (sts.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/vfh_datapath.sv @@
// Datapath: configuration, vector scaling and binning, count store and result register.
`timescale 1ns / 1ps
`default_nettype none
module vfh_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire vfh_pkg::ctrl_cmd_t                  cmd,
  output vfh_pkg::ctrl_sts_t                       sts,
  input  wire logic                                cfg_we,
  input  wire logic [vfh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vfh_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_func,
  input  wire logic signed [vfh_pkg::FLOW_W-1:0]   in_flow_x,
  input  wire logic signed [vfh_pkg::FLOW_W-1:0]   in_flow_y,
  input  wire logic                                in_counted,
  input  wire logic [vfh_pkg::EDGE_W-1:0]          in_read_col,
  input  wire logic [vfh_pkg::EDGE_W-1:0]          in_read_row,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [vfh_pkg::EDGE_W-1:0]               out_bin_col,
  output logic [vfh_pkg::EDGE_W-1:0]               out_bin_row,
  output logic [vfh_pkg::CNT_W-1:0]                out_count
);
  import vfh_pkg::*;

  localparam int MEM_DEPTH = MAX_EDGE * MAX_EDGE;

  logic [CFG_W-1:0]         bpu_r;
  logic [CFG_W-1:0]         edge_r;
  logic [CFG_W-1:0]         edge_eff;
  logic [EDGE_W-1:0]        edge_max;
  logic [EDGE_W-1:0]        offs;

  logic                     func_r;
  logic                     counted_r;
  logic signed [FLOW_W-1:0] flow_x_r;
  logic signed [FLOW_W-1:0] flow_y_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic [RMAG_W-1:0]        rmag_x_r, rmag_y_r;
  logic                     neg_x_r, neg_y_r;
  logic [EDGE_W-1:0]        col_r, row_r;
  logic [EDGE_W-1:0]        col_nxt, row_nxt;

  logic [CNT_W-1:0]         mem [MEM_DEPTH];
  logic [ADDR_W-1:0]        clr_addr_r;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [CNT_W-1:0]         mem_wdata;
  logic                     mem_we;
  logic [CNT_W-1:0]         rd_data_r;
  logic [CNT_W-1:0]         upd_cnt;

  logic                     out_valid_r;
  logic [EDGE_W-1:0]        out_col_r, out_row_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_free;

  function automatic logic [RMAG_W-1:0] round_mag(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    sum = mag + PROD_W'(1 << (FRAC_BITS - 1));
    return sum[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic logic [EDGE_W-1:0] clamp_bin(input logic [RMAG_W-1:0] rmag,
                                                  input logic             neg,
                                                  input logic [EDGE_W-1:0] off,
                                                  input logic [EDGE_W-1:0] top);
    logic signed [BINV_W-1:0] v;
    v = neg ? (BINV_W'(off) - BINV_W'(rmag)) : (BINV_W'(off) + BINV_W'(rmag));
    if (v < 0) begin
      return '0;
    end else if (v > BINV_W'(top)) begin
      return top;
    end else begin
      return v[EDGE_W-1:0];
    end
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpu_r  <= BPU_RESET;
      edge_r <= EDGE_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BINS_PER_UNIT: bpu_r  <= cfg_data;
        REG_EDGE_BINS:     edge_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (edge_r == '0) begin
      edge_eff = CFG_W'(1);
    end else if (edge_r > EDGE_LIMIT) begin
      edge_eff = EDGE_LIMIT;
    end else begin
      edge_eff = edge_r;
    end
  end

  assign edge_max = EDGE_W'(edge_eff - CFG_W'(1));
  assign offs     = EDGE_W'(edge_eff >> 1);

  // Item registers, scale, round and clamp
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r    <= in_func;
      counted_r <= in_counted;
      flow_x_r  <= in_flow_x;
      flow_y_r  <= in_flow_y;
    end
    if (cmd.mul) begin
      prod_x_r <= PROD_W'(flow_x_r) * PROD_W'($signed({1'b0, bpu_r}));
      prod_y_r <= PROD_W'(flow_y_r) * PROD_W'($signed({1'b0, bpu_r}));
    end
    if (cmd.rnd) begin
      rmag_x_r <= round_mag(prod_x_r);
      rmag_y_r <= round_mag(prod_y_r);
      neg_x_r  <= prod_x_r[PROD_W-1];
      neg_y_r  <= prod_y_r[PROD_W-1];
    end
    col_r <= col_nxt;
    row_r <= row_nxt;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.load_in) begin
      col_nxt = in_read_col;
      row_nxt = in_read_row;
    end else if (cmd.bin) begin
      col_nxt = clamp_bin(rmag_x_r, neg_x_r, offs, edge_max);
      row_nxt = clamp_bin(rmag_y_r, neg_y_r, offs, edge_max);
    end
  end

  // Count store: clearing sweep after reset, then read-modify-write per counted accumulate item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  assign upd_cnt = ((func_t'(func_r) == FUNC_ACCUM) && counted_r && (rd_data_r != COUNT_MAX))
                   ? rd_data_r + CNT_W'(1) : rd_data_r;

  always_comb begin
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.upd && (func_t'(func_r) == FUNC_ACCUM) && counted_r;
      mem_waddr = {row_r, col_r};
      mem_wdata = upd_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[{row_r, col_r}];
    end
  end

  // Result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_col_r <= col_r;
      out_row_r <= row_r;
      out_cnt_r <= upd_cnt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_bin_col  = out_col_r;
  assign out_bin_row  = out_row_r;
  assign out_count    = out_cnt_r;
  assign sts.clr_last = &clr_addr_r;
  assign sts.out_free = out_free;

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bin |=> ((CFG_W'(col_r) < edge_eff) && (CFG_W'(row_r) < edge_eff)))
    else $error("binned column or row outside the edge size");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && (rd_data_r == COUNT_MAX)) |-> (upd_cnt == COUNT_MAX))
    else $error("bin count wrapped past its maximum");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.clr) && !cmd.clr) |-> (clr_addr_r == '0))
    else $error("clearing sweep ended before the last entry");

  a_update_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> out_free)
    else $error("result loaded while the output register is held");

endmodule
`default_nettype wire
